FILE: hdl/dpfh_pkg.sv
package dpfh_pkg;

  localparam int MANT_BITS = 30;
  localparam int TEMP_W    = 14;
  localparam int HUM_W     = 14;
  localparam int DP_W      = 15;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam int DP_HIGH = 8000;
  localparam int DP_LOW  = -12000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SAT     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOG,
    BK_DIFF,
    BK_MUL0,
    BK_MUL1,
    BK_BPREP,
    BK_BSTART,
    BK_BDIV,
    BK_TPREP,
    BK_TSTART,
    BK_TDIV,
    BK_WB
  } bstate_e;

  // one classified item waiting for the back end
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     hzero;
    logic [3:0]               k;
    logic [MANT_BITS:0]       mant;
  } job_t;

  // log2(h) with f fraction bits, by repeated squaring; elaboration only
  function automatic longint log2_const(input int h, input int f);
    longint unsigned m;
    longint          frac;
    int              k;
    k    = 0;
    frac = 0;
    for (int j = 0; j < 31; j++) begin
      if ((h >> (j + 1)) != 0) begin
        k = j + 1;
      end
    end
    m = longint'(h) << (MANT_BITS - k);
    for (int i = 0; i < f; i++) begin
      m    = (m * m) >> MANT_BITS;
      frac = frac << 1;
      if (m >= (64'd2 << MANT_BITS)) begin
        frac = frac | 1;
        m    = m >> 1;
      end
    end
    return longint'(k) * (longint'(1) << f) + frac;
  endfunction

endpackage

FILE: hdl/dpfh_front.sv
module dpfh_front import dpfh_pkg::*; (
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,
  input  logic        full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [HUM_W-1:0] hum;
  logic [3:0]       k;

  assign hum = s_tdata_i[TEMP_W+HUM_W-1:TEMP_W];

  // leading one position
  always_comb begin
    k = 4'd0;
    for (int i = 0; i < HUM_W; i++) begin
      if (hum[i]) begin
        k = 4'(i);
      end
    end
  end

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

  always_comb begin
    job_o.temp  = $signed(s_tdata_i[TEMP_W-1:0]);
    job_o.hzero = (hum == '0);
    job_o.k     = k;
    // mantissa in [1,2) with MANT_BITS fraction bits
    job_o.mant  = (MANT_BITS+1)'(hum) << (5'd30 - {1'b0, k});
  end

endmodule

FILE: hdl/dpfh_queue.sv
module dpfh_queue import dpfh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/dpfh_div.sv
module dpfh_div #(
  parameter int NW = 46,
  parameter int DW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   r2, diff;
  logic          ge;

  // restoring division, one quotient bit per cycle
  assign r2   = {rem_q, quo_q[NW-1]};
  assign diff = r2 - {1'b0, den_q};
  assign ge   = (r2 >= {1'b0, den_q});

  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : r2[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/dpfh_back.sv
module dpfh_back import dpfh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DP_W-1:0]   dewpoint_o,
  output status_e           status_o
);

  localparam int F   = FRAC_BITS;
  localparam int LW  = F + 4;
  localparam int AW  = F + 35;
  localparam int NW  = F + 30;
  localparam int DW  = (F + 6 > 25) ? F + 6 : 25;
  localparam int SW  = F + 7;
  localparam int CW  = $clog2(F + 1);
  localparam logic [LW-1:0] L10K   = LW'(log2_const(10000, FRAC_BITS));
  localparam logic signed [SW-1:0] BETA_Q = SW'(141) <<< (F - 3);

  bstate_e state_q, state_d;

  job_t                   job_q;
  logic [MANT_BITS:0]     m_q;
  logic [F-1:0]           frac_q;
  logic [CW-1:0]          cnt_q;
  logic [LW-1:0]          dmag_q;
  logic                   dneg_q;
  logic [AW-1:0]          acc_q;
  logic signed [SW-1:0]   a_q, s_q, den_q;
  logic [SW-1:0]          smag_q;
  logic                   sneg_q;
  logic [27:0]            pb_q;
  logic [24:0]            db_q;
  logic signed [DP_W-1:0] res_q;
  status_e                rst_q;
  logic                   ov_q;
  logic [DP_W-1:0]        odp_q;
  status_e                ost_q;

  logic [61:0]            sq;
  logic [31:0]            ms;
  logic [LW:0]            dsum;
  logic [AW-31:0]         amag;
  logic [TEMP_W-1:0]      tmag;
  logic [14:0]            tden;
  logic                   div_start, div_done;
  logic [NW-1:0]          div_num, div_quot;
  logic [DW-1:0]          div_den;
  logic signed [SW-1:0]   bval;
  logic                   out_free;

  assign sq   = 62'(m_q) * 62'(m_q);
  assign ms   = sq[61:30];
  assign dsum = {1'b0, job_q.k, frac_q} - {1'b0, L10K};
  assign amag = (AW-30)'((acc_q + AW'(64'd1 << 29)) >> 30);
  assign tmag = job_q.temp[TEMP_W-1] ? TEMP_W'(-job_q.temp) : TEMP_W'(job_q.temp);
  assign tden = 15'(16'sd24304 + 16'(job_q.temp));
  assign bval = job_q.temp[TEMP_W-1] ? -SW'(div_quot) : SW'(div_quot);
  assign out_free = !ov_q || m_tready_i;

  assign pop_o      = (state_q == BK_IDLE) && job_valid_i;
  assign m_tvalid_o = ov_q;
  assign dewpoint_o = odp_q;
  assign status_o   = ost_q;

  always_comb begin
    div_start = 1'b0;
    div_num   = (NW'(pb_q) << F) + NW'(db_q >> 1);
    div_den   = DW'(db_q);
    if (state_q == BK_BSTART) begin
      div_start = 1'b1;
    end else if (state_q == BK_TSTART) begin
      div_num   = NW'(smag_q * 15'd24304) + NW'(den_q >>> 1);
      div_den   = DW'(den_q);
      div_start = !(den_q[SW-1] || den_q == '0);
    end
  end

  dpfh_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.hzero ? BK_WB : BK_LOG;
        end
      end
      BK_LOG: begin
        if (cnt_q == CW'(F - 1)) begin
          state_d = BK_DIFF;
        end
      end
      BK_DIFF:   state_d = BK_MUL0;
      BK_MUL0:   state_d = BK_MUL1;
      BK_MUL1:   state_d = BK_BPREP;
      BK_BPREP:  state_d = BK_BSTART;
      BK_BSTART: state_d = BK_BDIV;
      BK_BDIV: begin
        if (div_done) begin
          state_d = BK_TPREP;
        end
      end
      BK_TPREP:  state_d = BK_TSTART;
      BK_TSTART: state_d = div_start ? BK_TDIV : BK_WB;
      BK_TDIV: begin
        if (div_done) begin
          state_d = BK_WB;
        end
      end
      BK_WB: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_WB && out_free) begin
        ov_q <= 1'b1;
      end else if (m_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        job_q  <= job_i;
        m_q    <= job_i.mant;
        frac_q <= '0;
        cnt_q  <= '0;
        res_q  <= '0;
        rst_q  <= ST_INVALID;
      end
      BK_LOG: begin
        m_q    <= ms[31] ? ms[31:1] : ms[30:0];
        frac_q <= {frac_q[F-2:0], ms[31]};
        cnt_q  <= cnt_q + 1'b1;
      end
      BK_DIFF: begin
        dneg_q <= dsum[LW];
        dmag_q <= dsum[LW] ? LW'(-dsum) : dsum[LW-1:0];
      end
      BK_MUL0: acc_q <= AW'(dmag_q * LN2_Q30[14:0]);
      BK_MUL1: acc_q <= acc_q + (AW'(dmag_q * LN2_Q30[29:15]) << 15);
      BK_BPREP: begin
        a_q  <= dneg_q ? -SW'(amag) : SW'(amag);
        pb_q <= 28'(tmag * 15'd17625);
        db_q <= 25'(tden * 10'd1000);
      end
      BK_BDIV: begin
        if (div_done) begin
          s_q <= a_q + bval;
        end
      end
      BK_TPREP: begin
        den_q  <= BETA_Q - s_q;
        sneg_q <= s_q[SW-1];
        smag_q <= s_q[SW-1] ? SW'(-s_q) : SW'(s_q);
      end
      BK_TSTART: begin
        // denominator never goes non-positive for legal inputs; saturate high
        res_q <= DP_W'(DP_HIGH);
        rst_q <= ST_SAT;
      end
      BK_TDIV: begin
        if (div_done) begin
          if (!sneg_q) begin
            if (div_quot > NW'(DP_HIGH)) begin
              res_q <= DP_W'(DP_HIGH);
              rst_q <= ST_SAT;
            end else begin
              res_q <= DP_W'(div_quot);
              rst_q <= ST_OK;
            end
          end else begin
            if (div_quot > NW'(-DP_LOW)) begin
              res_q <= DP_W'(DP_LOW);
              rst_q <= ST_SAT;
            end else begin
              res_q <= -DP_W'(div_quot);
              rst_q <= ST_OK;
            end
          end
        end
      end
      BK_WB: begin
        if (out_free) begin
          odp_q <= res_q;
          ost_q <= rst_q;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/dewpoint_from_humidity.sv
// Dew point from air temperature and relative humidity (revised Magnus form).
// Input stream: s_axis_tdata_i carries temperature (signed, 0.01 C) in bits
// 13:0 and humidity (0.01 %) in bits 27:14. Output stream: m_axis_tdata_o
// carries the dew point (signed, 0.01 C, clamped to -120.00..80.00) in bits
// 14:0, and m_axis_tuser_o the status: ok, humidity zero, or saturated.
// A front end classifies each item (zero check, leading-one normalization)
// and writes it to a two-entry queue, so the input keeps accepting while
// the back end works. The back end runs the log2 squaring loop and then
// one shared bit-serial divider, first for b and then, unless the
// denominator is non-positive, for the final quotient; a zero-humidity
// item skips both. Results leave through an output register; while the
// receiver stalls the back end holds a finished result, the queue fills,
// and then s_axis_tready_o drops. Reset empties the queue and drops
// m_axis_tvalid_o.
module dewpoint_from_humidity import dpfh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [13:0] temperature, [27:14] humidity
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [14:0] dewpoint
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  logic            push, full, pop, qvalid;
  job_t            fjob, qjob;
  logic [DP_W-1:0] dp;
  status_e         st;

  dpfh_front u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (fjob)
  );

  dpfh_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (fjob),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .job_o   (qjob)
  );

  dpfh_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (qvalid),
    .job_i       (qjob),
    .pop_o       (pop),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .dewpoint_o  (dp),
    .status_o    (st)
  );

  assign m_axis_tdata_o = {1'b0, dp};
  assign m_axis_tuser_o = st;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_INVALID |-> m_axis_tdata_o == 16'd0)
    else $error("invalid status with nonzero dew point");

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $signed(m_axis_tdata_o[14:0]) <= 15'sd8000 &&
                        $signed(m_axis_tdata_o[14:0]) >= -15'sd12000)
    else $error("dew point out of range");

  a_sat_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_SAT |->
      $signed(m_axis_tdata_o[14:0]) == 15'sd8000 ||
      $signed(m_axis_tdata_o[14:0]) == -15'sd12000)
    else $error("saturated status without clamped value");

endmodule

FILE: tb/tb_top.sv
module tb_top import dpfh_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    logic signed [14:0] dp;
    status_e            st;
  } dew_t;

  typedef struct {
    logic [13:0] temp;
    logic [13:0] hum;
    bit          typed;
    dew_t        want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  dewpoint_from_humidity #(.FRAC_BITS(FRAC)) dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  dew_t dew_q[$];
  int   err_cnt = 0;
  int   idle_cyc = 0;
  int   send_pct = 0;
  int   stall_pct = 0;

  task automatic report_err(input string msg);
    $display("tb_top: mismatch: %s", msg);
    err_cnt++;
  endtask

  function automatic longint rnd_shift(input longint v, input int sh);
    longint mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
    return v < 0 ? -mag : mag;
  endfunction

  function automatic longint rnd_div(input longint n, input longint d);
    longint mag;
    mag = n < 0 ? -n : n;
    mag = (mag + d / 2) / d;
    return n < 0 ? -mag : mag;
  endfunction

  // log2 by repeated squaring of a normalized mantissa, 30 fraction bits
  function automatic longint log2_sq(input int unsigned h);
    longint unsigned m;
    longint          fr;
    int              k;
    k  = 0;
    fr = 0;
    while (k < 31 && (h >> (k + 1)) != 0) k++;
    m = longint'(h) << (MANT_BITS - k);
    for (int i = 0; i < FRAC; i++) begin
      m  = (m * m) >> MANT_BITS;
      fr = fr << 1;
      if (m >= (64'd2 << MANT_BITS)) begin
        fr = fr | 1;
        m  = m >> 1;
      end
    end
    return longint'(k) * (longint'(1) << FRAC) + fr;
  endfunction

  function automatic dew_t dewpoint_of(input logic [13:0] traw, input logic [13:0] hum);
    dew_t   r;
    longint t, a, b, s, den, td;
    longint beta_q;
    beta_q = longint'(141) << (FRAC - 3);
    t = longint'($signed(traw));
    r.st = ST_OK;
    if (hum == 0) begin
      r.dp = '0;
      r.st = ST_INVALID;
      return r;
    end
    a = rnd_shift((log2_sq(hum) - log2_sq(10000)) * longint'(LN2_Q30), MANT_BITS);
    b = rnd_div(longint'(17625) * t * (longint'(1) << FRAC), longint'(1000) * (24304 + t));
    s = a + b;
    den = beta_q - s;
    if (den <= 0) begin
      td = DP_HIGH;
      r.st = ST_SAT;
    end else begin
      td = rnd_div(longint'(24304) * s, den);
      if (td > DP_HIGH) begin
        td = DP_HIGH;
        r.st = ST_SAT;
      end else if (td < DP_LOW) begin
        td = DP_LOW;
        r.st = ST_SAT;
      end
    end
    r.dp = td[14:0];
    return r;
  endfunction

  function automatic row_t mk(input int t, input int h, input bit typed = 0,
                              input int dp = 0, input status_e st = ST_OK);
    row_t r;
    r.temp = t[13:0];
    r.hum = h[13:0];
    r.typed = typed;
    r.want.dp = dp[14:0];
    r.want.st = st;
    return r;
  endfunction

  task automatic send_item(input logic [13:0] t, input logic [13:0] h,
                           input bit typed, input dew_t want);
    if (send_pct != 0 && $urandom_range(99, 0) < send_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'b0, h, t};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    dew_q.push_back(typed ? want : dewpoint_of(t, h));
  endtask

  // receiver: random stall, compare each result with oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        idle_cyc <= 0;
        if (dew_q.size() == 0) begin
          report_err("result with nothing expected");
        end else begin
          dew_t w;
          w = dew_q.pop_front();
          if (m_axis_tdata_o[14:0] !== w.dp)
            report_err($sformatf("dewpoint %0d, want %0d",
                       $signed(m_axis_tdata_o[14:0]), w.dp));
          if (m_axis_tuser_o !== w.st)
            report_err($sformatf("status %0d, want %0d", m_axis_tuser_o, w.st));
        end
      end else if (s_axis_tvalid_i && s_axis_tready_o) begin
        idle_cyc <= 0;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
      m_axis_tready_i <= !(stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
      if (idle_cyc >= WATCH_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    dew_t none;
    int   pick;
    int   t, h;
    none = '{dp: '0, st: ST_OK};
    rows = '{
      mk(2000, 0, 1, 0, ST_INVALID),
      mk(-8192, 0, 1, 0, ST_INVALID),
      mk(8191, 0, 1, 0, ST_INVALID),
      mk(2500, 10000), mk(0, 10000), mk(-4000, 10000), mk(8000, 10000),
      mk(-4000, 1), mk(8000, 1), mk(-8192, 1, 1, DP_LOW, ST_SAT),
      mk(8191, 16383), mk(8191, 10000), mk(-8192, 16383), mk(2000, 16383),
      mk(2000, 5000), mk(-1234, 4321), mk(3000, 8191), mk(3000, 8192),
      mk(-4000, 100), mk(8000, 100), mk(100, 2), mk(8191, 1),
      mk(0, 1), mk(5555, 10922)
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].temp, rows[i].hum, rows[i].typed, rows[i].want);
    for (int ph = 0; ph < 4; ph++) begin
      send_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 53 : 26) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 53 : 26) : 0;
      // drain fully at the start of each phase
      s_axis_tvalid_i <= 1'b0;
      while (dew_q.size() != 0) @(posedge clk_i);
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(19, 0);
        if (pick < 14) begin
          t = $urandom_range(12000, 0) - 4000;
          h = $urandom_range(10000, 1);
        end else if (pick < 18) begin
          t = $urandom_range(16383, 0);
          h = $urandom_range(16383, 0);
        end else begin
          t = $urandom_range(16383, 0);
          h = pick == 18 ? 0 : $urandom_range(20, 1);
        end
        send_item(t[13:0], h[13:0], 0, none);
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (dew_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
